// ----- hdl/ppb_pkg.sv -----
// Shared types, constants and arithmetic helpers for the particle pixel blender.
// Used by ppb_over_prod and particle_pixel_blend; depends on nothing else.
package ppb_pkg;

	localparam logic [23:0] KEY_COLOUR = 24'hFF00FF;
	localparam logic [7:0]  UNIT       = 8'hFF;
	localparam logic [15:0] HALF_UNIT  = 16'd127;

	typedef struct packed {
		logic        covered;
		logic        textured;
		logic [31:0] texel;
		logic [7:0]  tint_red;
		logic [7:0]  tint_green;
		logic [7:0]  tint_blue;
		logic [7:0]  tint_mix;
		logic [7:0]  opacity_alpha;
		logic [31:0] dst_pixel;
		logic [15:0] particle_depth;
		logic [15:0] scene_depth;
	} pix_t;

	typedef struct packed {
		logic [31:0] out_pixel;
		logic        written;
	} res_t;

	// Four 16-bit products, one per ABGR byte lane (index 3 is alpha)
	typedef logic [3:0][15:0] prod_t;

	// Round-to-nearest divide by 255 for x <= 65025, via reciprocal with correction
	function automatic logic [7:0] div255_round(input logic [15:0] x);
		logic [16:0] y;
		logic [16:0] t;
		y = 17'(x) + 17'(HALF_UNIT);
		t = y + 17'd1 + 17'(y[16:8]);
		return t[15:8];
	endfunction

	// Byte product widened to 16 bits
	function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
		return 16'(a) * 16'(b);
	endfunction

endpackage

// ----- hdl/ppb_over_prod.sv -----
// Source-over products for one ABGR8888 pixel pair: s*sa + d*(255-sa) per colour
// lane and da*(255-sa) for alpha. Depends on ppb_pkg.
module ppb_over_prod (
	input  logic [31:0]      src,
	input  logic [31:0]      dst,
	output ppb_pkg::prod_t   prod
);

	logic [7:0] sa;
	logic [7:0] inv;

	assign sa  = src[31:24];
	assign inv = ppb_pkg::UNIT - sa;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = ppb_pkg::mul8(src[8*k +: 8], sa) + ppb_pkg::mul8(dst[8*k +: 8], inv);
		end
		prod[3] = ppb_pkg::mul8(dst[31:24], inv);
	end

endmodule

// ----- hdl/particle_pixel_blend.sv -----
// Particle pixel compositor top level: four-stage pipeline with valid/stall channels.
// Depends on ppb_pkg and ppb_over_prod.
//
// Takes one pixel transaction per clock while pix_stall is low and returns one result per
// pixel, in order, with res_valid rising once it has passed through stages 1 to 4. Stage 1
// runs the depth and coverage test, the magenta key match and the tint and opacity
// multiplies; stage 2 does the divides by 255 and picks the source colour; stage 3 forms
// the source-over products; stage 4 divides them and holds the result. Each stage loads
// whenever the stage after it is empty or moving, so a stalled output fills the bubbles in
// the pipe before pix_stall rises, and throughput stays at one pixel per clock while
// res_stall is low.
module particle_pixel_blend (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_stall,
	input  ppb_pkg::pix_t  pix,
	output logic           res_valid,
	input  logic           res_stall,
	output ppb_pkg::res_t  res
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4    = !v_s4 || !res_stall;
	assign adv_s3    = !v_s3 || adv_s4;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign pix_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= pix_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: tests and first multiplies
	logic        skip_s1, textured_s1, tint_on_s1;
	logic [31:0] texel_s1, dst_s1;
	logic [23:0] tint_s1;
	logic [7:0]  opacity_s1;
	logic [2:0][15:0] mix_s1;
	logic [15:0] alpha_prod_s1;

	logic        skip_c1;
	logic [7:0]  mix_inv_c1;
	logic [23:0] tint_c1;
	logic [2:0][15:0] mix_c1;

	always_comb begin
		tint_c1    = {pix.tint_blue, pix.tint_green, pix.tint_red};
		mix_inv_c1 = ppb_pkg::UNIT - pix.tint_mix;
		skip_c1    = !pix.covered || (pix.particle_depth >= pix.scene_depth) ||
		             (pix.textured && (pix.texel[23:0] == ppb_pkg::KEY_COLOUR));
		for (int k = 0; k < 3; k++) begin
			mix_c1[k] = ppb_pkg::mul8(pix.texel[8*k +: 8], mix_inv_c1) +
			            ppb_pkg::mul8(tint_c1[8*k +: 8], pix.tint_mix);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			skip_s1       <= skip_c1;
			textured_s1   <= pix.textured;
			tint_on_s1    <= (pix.tint_mix != 8'd0);
			texel_s1      <= pix.texel;
			dst_s1        <= pix.dst_pixel;
			tint_s1       <= tint_c1;
			opacity_s1    <= pix.opacity_alpha;
			mix_s1        <= mix_c1;
			alpha_prod_s1 <= ppb_pkg::mul8(pix.texel[31:24], pix.opacity_alpha);
		end
	end

	// Stage 2: divides by 255, source selection
	logic        skip_s2;
	logic [31:0] src_s2, dst_s2;

	logic [7:0]  alpha_c2;
	logic [23:0] tex_rgb_c2;

	always_comb begin
		alpha_c2 = ppb_pkg::div255_round(alpha_prod_s1);
		for (int k = 0; k < 3; k++) begin
			tex_rgb_c2[8*k +: 8] = tint_on_s1 ? ppb_pkg::div255_round(mix_s1[k])
			                                  : texel_s1[8*k +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			// Drop textured pixels whose scaled alpha vanished
			skip_s2 <= skip_s1 || (textured_s1 && (alpha_c2 == 8'd0));
			src_s2  <= textured_s1 ? {alpha_c2, tex_rgb_c2} : {opacity_s1, tint_s1};
			dst_s2  <= dst_s1;
		end
	end

	// Stage 3: source-over products
	logic        skip_s3;
	logic [31:0] src_s3, dst_s3;
	ppb_pkg::prod_t prod_s3;
	ppb_pkg::prod_t prod_c3;

	ppb_over_prod u_over_prod (
		.src  (src_s2),
		.dst  (dst_s2),
		.prod (prod_c3)
	);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			skip_s3 <= skip_s2;
			src_s3  <= src_s2;
			dst_s3  <= dst_s2;
			prod_s3 <= prod_c3;
		end
	end

	// Stage 4: final divides and result register
	ppb_pkg::res_t res_s4;
	ppb_pkg::res_t res_c4;
	logic [7:0]    sa_c4;
	logic [31:0]   over_c4;

	always_comb begin
		sa_c4 = src_s3[31:24];
		for (int k = 0; k < 3; k++) begin
			over_c4[8*k +: 8] = ppb_pkg::div255_round(prod_s3[k]);
		end
		over_c4[31:24] = 8'(sa_c4 + ppb_pkg::div255_round(prod_s3[3]));

		res_c4.written = !skip_s3;
		priority if (skip_s3 || (sa_c4 == 8'd0)) begin
			res_c4.out_pixel = dst_s3;
		end else if (sa_c4 == ppb_pkg::UNIT) begin
			res_c4.out_pixel = src_s3;
		end else begin
			res_c4.out_pixel = over_c4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			res_s4 <= res_c4;
		end
	end

	assign res_valid = v_s4;
	assign res       = res_s4;

	// An empty first stage never pushes back on the input
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !pix_stall)
		else $error("input stalled with empty first stage");

	// A held stage 3 keeps its transaction
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !adv_s3) |=> (v_s3 && $stable(src_s3) && $stable(skip_s3)))
		else $error("stage 3 lost its transaction while held");

	// A transaction leaving stage 1 lands in stage 2
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv_s2) |=> v_s2)
		else $error("transaction lost between stage 1 and stage 2");

	// Output advances whenever downstream is free
	a_out_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !res_stall) |=> v_s4)
		else $error("result not produced from stage 3");

endmodule

// ----- test/particle_pixel_blend_tb.sv -----
// Self-checking testbench for particle_pixel_blend: directed and random pixel transactions
// checked against an in-bench source-over compositor model, with random idling on both sides.
// Depends on ppb_pkg and the particle_pixel_blend RTL.
`timescale 1ns / 1ps

module particle_pixel_blend_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	ppb_pkg::pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ppb_pkg::res_t res;

	ppb_pkg::pix_t pend_q[$];
	ppb_pkg::res_t blend_q[$];
	ppb_pkg::res_t want;
	logic pix_taken = 1'b0;
	int unsigned n_sent = 0;
	int unsigned n_err = 0;
	logic calm;

	particle_pixel_blend u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] div255_near(input int unsigned x);
		return 8'((x + 127) / 255);
	endfunction

	function automatic logic [7:0] tint_lerp(input int unsigned c, input int unsigned t,
			input int unsigned m);
		return div255_near(c * (255 - m) + t * m);
	endfunction

	function automatic logic [31:0] src_over(input logic [31:0] s, input logic [31:0] d);
		int unsigned sa;
		int unsigned inv;
		int unsigned k;
		logic [31:0] o;
		sa = s[31:24];
		if (sa == 0)
			return d;
		if (sa == 255)
			return s;
		inv = 255 - sa;
		for (k = 0; k < 3; k++)
			o[8*k +: 8] = div255_near(s[8*k +: 8] * sa + d[8*k +: 8] * inv);
		o[31:24] = 8'(sa + div255_near(d[31:24] * inv));
		return o;
	endfunction

	function automatic ppb_pkg::res_t blend_pixel(input ppb_pkg::pix_t p);
		ppb_pkg::res_t r;
		logic [7:0] sa, sb, sg, sr;
		logic [31:0] src;
		bit skip;
		r.out_pixel = p.dst_pixel;
		r.written = 1'b0;
		src = '0;
		skip = !p.covered || p.particle_depth >= p.scene_depth;
		if (!skip && p.textured) begin
			if (p.texel[23:0] == ppb_pkg::KEY_COLOUR) begin
				skip = 1'b1;
			end else begin
				sa = p.texel[31:24];
				sb = p.texel[23:16];
				sg = p.texel[15:8];
				sr = p.texel[7:0];
				if (p.tint_mix != 0) begin
					sr = tint_lerp(sr, p.tint_red, p.tint_mix);
					sg = tint_lerp(sg, p.tint_green, p.tint_mix);
					sb = tint_lerp(sb, p.tint_blue, p.tint_mix);
				end
				sa = div255_near(sa * p.opacity_alpha);
				skip = (sa == 0);
				src = {sa, sb, sg, sr};
			end
		end else begin
			src = {p.opacity_alpha, p.tint_blue, p.tint_green, p.tint_red};
		end
		if (!skip) begin
			r.out_pixel = src_over(src, p.dst_pixel);
			r.written = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_pix(input bit cov, input bit tex, input logic [31:0] tx,
			input logic [7:0] tr, input logic [7:0] tg, input logic [7:0] tb,
			input logic [7:0] mx, input logic [7:0] op, input logic [31:0] dst,
			input logic [15:0] pd, input logic [15:0] sd);
		ppb_pkg::pix_t p;
		p.covered = cov;
		p.textured = tex;
		p.texel = tx;
		p.tint_red = tr;
		p.tint_green = tg;
		p.tint_blue = tb;
		p.tint_mix = mx;
		p.opacity_alpha = op;
		p.dst_pixel = dst;
		p.particle_depth = pd;
		p.scene_depth = sd;
		pend_q.push_back(p);
	endtask

	// Mostly covered, depth-passing pixels so that the blend path is exercised
	task automatic queue_random(input int unsigned n);
		ppb_pkg::pix_t p;
		int unsigned i;
		for (i = 0; i < n; i++) begin
			p.covered = ($urandom_range(99) < 88);
			p.textured = 1'($urandom_range(1));
			case ($urandom_range(19))
				0: p.texel = {8'($urandom_range(255)), ppb_pkg::KEY_COLOUR};
				1: p.texel = {8'hFF, 24'($urandom)};
				2: p.texel = {8'h00, 24'($urandom)};
				default: p.texel = $urandom;
			endcase
			p.tint_red = pick_byte();
			p.tint_green = pick_byte();
			p.tint_blue = pick_byte();
			p.tint_mix = pick_byte();
			p.opacity_alpha = pick_byte();
			p.dst_pixel = $urandom;
			p.particle_depth = 16'($urandom_range(65535));
			case ($urandom_range(9))
				0: p.scene_depth = p.particle_depth;
				1: p.scene_depth = 16'($urandom_range(p.particle_depth));
				default: begin
					if (p.particle_depth == 16'hFFFF)
						p.particle_depth = 16'hFFFE;
					p.scene_depth = 16'($urandom_range(65535, p.particle_depth + 1));
				end
			endcase
			pend_q.push_back(p);
		end
	endtask

	// No idling on either side for a stretch of the random run
	assign calm = (n_sent >= 700) && (n_sent < 1000);

	always @(negedge clk) begin
		if (arst_n && (!pix_valid || pix_taken)) begin
			if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
				pix <= pend_q.pop_front();
				pix_valid <= 1'b1;
			end else begin
				pix_valid <= 1'b0;
			end
		end
		res_stall <= arst_n && !calm && ($urandom_range(99) < 22);
	end

	always @(posedge clk) begin
		pix_taken <= pix_valid && !pix_stall;
		if (arst_n && res_valid && !res_stall) begin
			if (blend_q.size() == 0) begin
				$error("unexpected result: out_pixel %h written %b", res.out_pixel, res.written);
				n_err++;
			end else begin
				want = blend_q.pop_front();
				if (res.out_pixel !== want.out_pixel) begin
					$error("out_pixel: expected %h, got %h", want.out_pixel, res.out_pixel);
					n_err++;
				end
				if (res.written !== want.written) begin
					$error("written: expected %b, got %b", want.written, res.written);
					n_err++;
				end
			end
		end
		if (arst_n && pix_valid && !pix_stall) begin
			blend_q.push_back(blend_pixel(pix));
			n_sent++;
		end
	end

	initial begin
		// uncovered, depth equal, depth behind the scene
		queue_pix(0, 1, 32'h80402010, 8'h11, 8'h22, 8'h33, 8'h40, 8'hFF, 32'hDEADBEEF,
			16'h0100, 16'h0200);
		queue_pix(1, 0, 32'h0, 8'h11, 8'h22, 8'h33, 8'h00, 8'h80, 32'h12345678,
			16'h4000, 16'h4000);
		queue_pix(1, 1, 32'hFF102030, 8'h11, 8'h22, 8'h33, 8'h00, 8'hFF, 32'h12345678,
			16'hFFFF, 16'h0000);
		// magenta key, textured and not
		queue_pix(1, 1, 32'hFFFF00FF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 32'hA5A5A5A5,
			16'h0000, 16'hFFFF);
		queue_pix(1, 1, 32'h00FF00FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 32'h5A5A5A5A,
			16'h0001, 16'h0002);
		queue_pix(1, 0, 32'hFFFF00FF, 8'h10, 8'h20, 8'h30, 8'h00, 8'hC0, 32'h80808080,
			16'h0000, 16'h0001);
		// textured: full alpha, tint extremes, mid tint
		queue_pix(1, 1, 32'hFF123456, 8'hAA, 8'hBB, 8'hCC, 8'h00, 8'hFF, 32'h00000000,
			16'h1000, 16'h2000);
		queue_pix(1, 1, 32'hFF123456, 8'hAA, 8'hBB, 8'hCC, 8'hFF, 8'hFF, 32'hFFFFFFFF,
			16'h1000, 16'h2000);
		queue_pix(1, 1, 32'h80FFFFFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 32'h40404040,
			16'h1000, 16'h2000);
		queue_pix(1, 1, 32'h7F00FF00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hC8, 32'hFF0000FF,
			16'h1000, 16'h2000);
		// textured: zero opacity, zero texel alpha, alpha rounding to zero
		queue_pix(1, 1, 32'hFF808080, 8'h10, 8'h10, 8'h10, 8'h20, 8'h00, 32'h11223344,
			16'h0000, 16'h0100);
		queue_pix(1, 1, 32'h00808080, 8'h10, 8'h10, 8'h10, 8'h20, 8'hFF, 32'h11223344,
			16'h0000, 16'h0100);
		queue_pix(1, 1, 32'h01808080, 8'h10, 8'h10, 8'h10, 8'h00, 8'h01, 32'h11223344,
			16'h0000, 16'h0100);
		queue_pix(1, 1, 32'h01808080, 8'h10, 8'h10, 8'h10, 8'h00, 8'h80, 32'h11223344,
			16'h0000, 16'h0100);
		// untextured: zero, full and partial opacity
		queue_pix(1, 0, 32'h0, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 32'hCAFEF00D,
			16'h0000, 16'h0001);
		queue_pix(1, 0, 32'h0, 8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 32'hCAFEF00D,
			16'h0000, 16'h0001);
		queue_pix(1, 0, 32'h0, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h01, 32'hFFFFFFFF,
			16'h0000, 16'h0001);
		queue_pix(1, 0, 32'h0, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'hFE, 32'h00000000,
			16'h0000, 16'h0001);
		// all ones and all zeros
		queue_pix(1, 1, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF,
			16'hFFFE, 16'hFFFF);
		queue_pix(0, 0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h00000000,
			16'h0000, 16'h0000);
		queue_pix(1, 1, 32'hC0FEFEFE, 8'h01, 8'h01, 8'h01, 8'hFE, 8'hFE, 32'h7F7F7F7F,
			16'h00FF, 16'hFF00);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// hold off the random run until the directed pixels have all drained
		while (pend_q.size() != 0 || pix_valid || blend_q.size() != 0)
			@(negedge clk);
		queue_random(1730);
		while (pend_q.size() != 0 || pix_valid || blend_q.size() != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);

		if (n_err == 0)
			$display("particle_pixel_blend: match");
		else
			$display("particle_pixel_blend: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("particle_pixel_blend: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ppb_pkg.sv
hdl/ppb_over_prod.sv
hdl/particle_pixel_blend.sv
test/particle_pixel_blend_tb.sv
